FILE: rtl/core/sri_pkg.sv
`timescale 1ns / 1ps

package sri_pkg;

  localparam int RADIX_W = 11;
  localparam int VAL_W   = 10;
  localparam int IDX_W   = 10;

  localparam int PERM_DEPTH_DEF = 1024;
  localparam int INDEX_BITS_DEF = 31;
  localparam int FRAC_BITS_DEF  = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

endpackage

FILE: rtl/core/scrambled_radical_inverse.sv
// Load requests give no result.
// A compute request with n base digits (n = 0 for a zero index) presents its result and
// frees the input in the same cycle; per digit the bit-serial divider works through an
// INDEX_BITS-bit dividend for the split and a FRAC_BITS + 11-bit dividend for the Horner
// step, started from the S_SPLIT_GO and S_HORN_GO control states.
// One request is worked on at a time; the next may enter while a result waits.
// Reset clears control state and sets radix to 2; the table is undefined.
`timescale 1ns / 1ps

module scrambled_radical_inverse #(
  parameter int PERM_DEPTH = sri_pkg::PERM_DEPTH_DEF,
  parameter int INDEX_BITS = sri_pkg::INDEX_BITS_DEF,
  parameter int FRAC_BITS  = sri_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [sri_pkg::RADIX_W-1:0]              cfg_wdata_i,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // entry_index, entry_value, sample_index, zero padding
  input  logic [(((20 + INDEX_BITS) + 7) >> 3 << 3)-1:0] s_axis_tdata,
  // mode
  input  logic                                     s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // fraction, zero padding
  output logic [((FRAC_BITS + 7) >> 3 << 3)-1:0]   m_axis_tdata,
  // saturated
  output logic                                     m_axis_tuser
);

  localparam int NW    = FRAC_BITS + sri_pkg::VAL_W + 1;
  localparam int DW    = (INDEX_BITS > NW) ? INDEX_BITS : NW;
  localparam int DCW   = $clog2(DW + 1);
  localparam int PAW   = $clog2(PERM_DEPTH);
  localparam int ACC_W = FRAC_BITS + sri_pkg::VAL_W;
  localparam int SW    = $clog2(INDEX_BITS);
  localparam int CW    = $clog2(INDEX_BITS + 1);
  localparam int OW    = (FRAC_BITS + 7) >> 3 << 3;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_SPLIT_GO   = 3'd1;
  localparam logic [2:0] S_SPLIT_WAIT = 3'd2;
  localparam logic [2:0] S_READ       = 3'd3;
  localparam logic [2:0] S_HORN_GO    = 3'd4;
  localparam logic [2:0] S_HORN_WAIT  = 3'd5;
  localparam logic [2:0] S_FINISH     = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [sri_pkg::RADIX_W-1:0] radix_q, radix_d;
  logic [sri_pkg::RADIX_W-1:0] base_q, base_d, base_clamped;
  logic [INDEX_BITS-1:0]       num_q, num_d;
  logic [CW-1:0]               cnt_q, cnt_d, cnt_dec;
  logic [PAW-1:0]              stk_q [INDEX_BITS];
  logic [ACC_W-1:0]            acc_q, acc_d;
  logic                        m_valid_q, m_valid_d;
  logic [FRAC_BITS-1:0]        frac_q;
  logic                        sat_q;

  logic                        s_acc;
  logic                        in_mode;
  logic [sri_pkg::IDX_W-1:0]   in_idx;
  logic [sri_pkg::VAL_W-1:0]   in_val;
  logic [INDEX_BITS-1:0]       in_sample;

  logic                        div_start, div_busy, div_done;
  logic [DCW-1:0]              div_len;
  logic [DW-1:0]               div_dividend, div_quot;
  logic [sri_pkg::RADIX_W-1:0] div_rem;
  logic [NW-1:0]               numerator;

  logic                        ram_we, ram_re;
  logic [PAW-1:0]              ram_raddr;
  logic [sri_pkg::VAL_W-1:0]   ram_rdata;

  logic                        push;
  logic                        out_load;
  logic                        over;

  assign in_mode   = s_axis_tuser;
  assign in_idx    = s_axis_tdata[sri_pkg::IDX_W-1:0];
  assign in_val    = s_axis_tdata[sri_pkg::IDX_W +: sri_pkg::VAL_W];
  assign in_sample = s_axis_tdata[sri_pkg::IDX_W + sri_pkg::VAL_W +: INDEX_BITS];

  assign s_axis_tready = state_q == S_IDLE;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    base_clamped = radix_q;
    if (radix_q < sri_pkg::RADIX_MIN) begin
      base_clamped = sri_pkg::RADIX_MIN;
    end else if (radix_q > sri_pkg::RADIX_W'(PERM_DEPTH)) begin
      base_clamped = sri_pkg::RADIX_W'(PERM_DEPTH);
    end
  end

  assign ram_we = s_acc && (in_mode == sri_pkg::MODE_LOAD) &&
                  ({1'b0, in_idx} < (sri_pkg::IDX_W + 1)'(PERM_DEPTH));

  assign cnt_dec   = cnt_q - CW'(1);
  assign ram_re    = state_q == S_READ;
  assign ram_raddr = stk_q[cnt_dec[SW-1:0]];

  // The mapped digit sits above the fraction bits, so this is p * 2^F + acc.
  assign numerator = NW'({ram_rdata, {FRAC_BITS{1'b0}}}) + NW'(acc_q);

  always_comb begin
    div_start    = 1'b0;
    div_len      = DCW'(INDEX_BITS);
    div_dividend = DW'(num_q) << (DW - INDEX_BITS);
    if (state_q == S_HORN_GO) begin
      div_start    = 1'b1;
      div_len      = DCW'(NW);
      div_dividend = DW'(numerator) << (DW - NW);
    end else if (state_q == S_SPLIT_GO) begin
      div_start = 1'b1;
    end
  end

  assign over     = |acc_q[ACC_W-1:FRAC_BITS];
  assign out_load = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready);
  assign push     = (state_q == S_SPLIT_WAIT) && div_done;

  always_comb begin
    state_d   = state_q;
    radix_d   = radix_q;
    base_d    = base_q;
    num_d     = num_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    if (cfg_we_i) begin
      radix_d = cfg_wdata_i;
    end
    if (out_load) begin
      m_valid_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (s_acc && (in_mode == sri_pkg::MODE_COMPUTE)) begin
          base_d  = base_clamped;
          num_d   = in_sample;
          cnt_d   = '0;
          acc_d   = '0;
          state_d = (in_sample == '0) ? S_FINISH : S_SPLIT_GO;
        end
      end
      S_SPLIT_GO: begin
        state_d = S_SPLIT_WAIT;
      end
      S_SPLIT_WAIT: begin
        if (div_done) begin
          num_d   = div_quot[INDEX_BITS-1:0];
          cnt_d   = cnt_q + CW'(1);
          state_d = (div_quot[INDEX_BITS-1:0] == '0) ? S_READ : S_SPLIT_GO;
        end
      end
      S_READ: begin
        cnt_d   = cnt_dec;
        state_d = S_HORN_GO;
      end
      S_HORN_GO: begin
        state_d = S_HORN_WAIT;
      end
      S_HORN_WAIT: begin
        if (div_done) begin
          acc_d   = div_quot[ACC_W-1:0];
          state_d = (cnt_q == '0) ? S_FINISH : S_READ;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      radix_q   <= sri_pkg::RADIX_RESET;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      radix_q   <= radix_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    num_q  <= num_d;
    acc_q  <= acc_d;
    if (push) begin
      stk_q[cnt_q[SW-1:0]] <= div_rem[PAW-1:0];
    end
    if (out_load) begin
      frac_q <= over ? '1 : acc_q[FRAC_BITS-1:0];
      sat_q  <= over;
    end
  end

  sri_divider #(
    .DW (DW),
    .DCW(DCW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .len_i      (div_len),
    .dividend_i (div_dividend),
    .divisor_i  (base_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  sri_perm_ram #(
    .DEPTH(PERM_DEPTH),
    .AW   (PAW)
  ) u_perm (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_idx[PAW-1:0]),
    .wdata_i(in_val),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OW'(frac_q);
  assign m_axis_tuser  = sat_q;

  a_idle_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_busy)
    else $error("divider busy while the block accepts requests");

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_SPLIT_WAIT || state_q == S_HORN_WAIT))
    else $error("divider finished outside a wait state");

  a_stack_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(INDEX_BITS))
    else $error("digit stack overflow");

  a_zero_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && in_mode == sri_pkg::MODE_COMPUTE && in_sample == '0)
    |=> (state_q == S_FINISH && acc_q == '0))
    else $error("zero index did not go straight to the result");

  a_base_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |->
    (base_q >= sri_pkg::RADIX_MIN && base_q <= sri_pkg::RADIX_W'(PERM_DEPTH)))
    else $error("working base out of range");

endmodule

FILE: rtl/core/sri_divider.sv
`timescale 1ns / 1ps

module sri_divider #(
  parameter int DW  = 43,
  parameter int DCW = $clog2(DW + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DCW-1:0]              len_i,
  input  logic [DW-1:0]               dividend_i,
  input  logic [sri_pkg::RADIX_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [DW-1:0]               quotient_o,
  output logic [sri_pkg::RADIX_W-1:0] remainder_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [DCW-1:0]              cnt_q, cnt_d;
  logic [DW-1:0]               work_q, work_d;
  logic [sri_pkg::RADIX_W-1:0] rem_q, rem_d;
  logic [sri_pkg::RADIX_W:0]   trial;
  logic                        ge;

  // One restoring step: the next dividend bit enters the partial remainder.
  assign trial = {rem_q, work_q[DW-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = len_i;
      work_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      work_d = {work_q[DW-2:0], ge};
      rem_d  = ge ? sri_pkg::RADIX_W'(trial - {1'b0, divisor_i})
                  : sri_pkg::RADIX_W'(trial);
      cnt_d  = cnt_q - DCW'(1);
      if (cnt_q == DCW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = work_q;
  assign remainder_o = rem_q;

endmodule

FILE: rtl/core/sri_perm_ram.sv
`timescale 1ns / 1ps

module sri_perm_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [sri_pkg::VAL_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [sri_pkg::VAL_W-1:0] rdata_o
);

  logic [sri_pkg::VAL_W-1:0] mem_q [DEPTH];
  logic [sri_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
